// File: hdl/lspq_pkg.sv
// ----------------------------------------------------------------------------
// lspq_pkg: shared types and constants of the priority queue
// Word formats, status codes and the control bundle that drives each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lspq_pkg;

  localparam int unsigned DEPTH_DEF    = 8;
  localparam int unsigned TAG_BITS_DEF = 32;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned PAYLOAD_W    = 32;
  localparam int unsigned OCC_W        = 4;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [PRIO_W-1:0]  priority_req;
    logic [PAYLOAD_W-1:0]      payload;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [PAYLOAD_W-1:0]      out_payload;
    logic [OCC_W-1:0]          occupancy;
  } out_word_t;

  // Per-cell control: an accepted insert, an accepted remove, and whether
  // the cell currently holds an entry.
  typedef struct packed {
    logic ins;
    logic rem;
    logic occupied;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/linear_scan_priority_queue.sv
// ----------------------------------------------------------------------------
// linear_scan_priority_queue: bounded minimum-first priority queue
// Inserts (priority, tag) entries and removes the smallest priority, oldest
// first on ties, with one status word per request.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                          Word          Direction
//   -------  -------------------------------  ------------  ---------
//   in       in_valid_i, in_ready_o           in_word_i     request
//   out      out_valid_o, out_ready_i         out_word_o    result
//
// Each accepted word gives its result word on the next cycle; a new request
// is taken every cycle as long as the result register is free or is being
// drained in the same cycle, so the queue sustains one word per clock.
// The minimum search is spread over the chain: entries are kept sorted by
// priority and then by age, each cell comparing the new priority with its
// own, so the head cell always holds the entry a remove returns.
// Reset clears the entry count and the result valid flag; entry storage is
// not cleared, since no slot at or above the count is ever read.
// A stalled result holds its word and blocks new requests until it is taken.
//
`default_nettype none

module linear_scan_priority_queue import lspq_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic fire, is_remove, is_full, is_empty;
  logic ins_ok, rem_ok;
  logic [TAG_BITS-1:0] new_tag;

  logic                     gt_w   [DEPTH];
  logic signed [PRIO_W-1:0] prio_w [DEPTH];
  logic [TAG_BITS-1:0]      tag_w  [DEPTH];

  // The result register frees up either when empty or when drained now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign is_remove = (in_word_i.kind == KIND_REMOVE);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign ins_ok    = fire && !is_remove && !is_full;
  assign rem_ok    = fire && is_remove && !is_empty;
  assign new_tag   = TAG_BITS'(in_word_i.payload);

  // Cell chain. Cell 0 is the head; an insert pushes larger entries one slot
  // to the right, a remove pulls every entry one slot to the left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t               ctrl;
    logic                     left_gt;
    logic signed [PRIO_W-1:0] left_prio, right_prio;
    logic [TAG_BITS-1:0]      left_tag, right_tag;

    assign ctrl.ins      = ins_ok;
    assign ctrl.rem      = rem_ok;
    assign ctrl.occupied = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_prio = '0;
      assign left_tag  = '0;
    end else begin : g_body
      assign left_gt   = gt_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_tag  = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = prio_w[i];
      assign right_tag  = tag_w[i];
    end else begin : g_inner
      assign right_prio = prio_w[i+1];
      assign right_tag  = tag_w[i+1];
    end

    lspq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_prio_i  (in_word_i.priority_req),
      .new_tag_i   (new_tag),
      .left_gt_i   (left_gt),
      .left_prio_i (left_prio),
      .left_tag_i  (left_tag),
      .right_prio_i(right_prio),
      .right_tag_i (right_tag),
      .gt_o        (gt_w[i]),
      .prio_o      (prio_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  // Count update and result formation.
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end
    if (fire) begin
      out_valid_d          = 1'b1;
      out_d.out_priority   = '0;
      out_d.out_payload    = '0;
      out_d.occupancy      = OCC_W'(count_d);
      if (is_remove) begin
        if (is_empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.status       = ST_REMOVED;
          out_d.out_priority = prio_w[0];
          out_d.out_payload  = PAYLOAD_W'(tag_w[0]);
        end
      end else begin
        out_d.status = is_full ? ST_FULL : ST_INSERTED;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/lspq_cell.sv
// ----------------------------------------------------------------------------
// lspq_cell: one slot of the sorted entry chain
// Holds one priority and tag, and loads the new entry, its left neighbor or
// its right neighbor as the queue inserts or removes.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_cell import lspq_pkg::*; #(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic signed [PRIO_W-1:0] new_prio_i,
  input  wire logic [TAG_BITS-1:0]      new_tag_i,
  input  wire logic                     left_gt_i,
  input  wire logic signed [PRIO_W-1:0] left_prio_i,
  input  wire logic [TAG_BITS-1:0]      left_tag_i,
  input  wire logic signed [PRIO_W-1:0] right_prio_i,
  input  wire logic [TAG_BITS-1:0]      right_tag_i,
  output logic                          gt_o,
  output logic signed [PRIO_W-1:0]      prio_o,
  output logic [TAG_BITS-1:0]           tag_o
);

  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;

  // The new entry belongs at or before this slot when the slot is free or
  // holds a strictly larger priority; equal priorities stay ahead of it.
  assign gt_o = !ctrl_i.occupied || (new_prio_i < prio_q);

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end else begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end
    end else if (ctrl_i.rem) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

// File: hdl/lspq_checker.sv
// ----------------------------------------------------------------------------
// lspq_checker: port-level checks for the priority queue
// Watches the top-level handshakes and result words over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_checker import lspq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_o
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // An empty result register never refuses a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with no result pending");

  // Every accepted request shows its result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  // The queue never reports more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_word_o.occupancy) <= DEPTH)
    else $error("occupancy above depth");

  // An empty report means nothing is held afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_EMPTY |-> out_word_o.occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind linear_scan_priority_queue lspq_checker #(
  .DEPTH(DEPTH)
) u_lspq_checker (.*);

`default_nettype wire
